/* rtl/core/ttvf_pkg.sv */
// Shared constants and types for the thermistor temperature to VCO frequency block.
// Table geometry, datapath widths, register offsets, clamp codes and FSM states.
// No dependencies.
package ttvf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  // fractional index: table index above 16 fraction bits, plus one carry bit
  localparam int QW        = TBL_AW + 17;
  localparam int MA_W      = (QW + 1 > 25) ? QW + 1 : 25;
  localparam int VP_W      = MA_W + 25;
  localparam int DIV_STEPS = 17;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_INTERP = 2'd0;
  localparam logic [1:0] KIND_BELOW  = 2'd1;
  localparam logic [1:0] KIND_ABOVE  = 2'd2;
  localparam logic [1:0] KIND_FLAT   = 2'd3;

  localparam logic [2:0] REG_ZERO_VOLT_FREQ    = 3'd0;
  localparam logic [2:0] REG_MAX_FREQ          = 3'd1;
  localparam logic [2:0] REG_VOLT_TO_FREQ_GAIN = 3'd2;
  localparam logic [2:0] REG_VOLT_PER_POINT    = 3'd3;
  localparam logic [2:0] REG_VOLT_AT_START     = 3'd4;
  localparam logic [2:0] REG_VOLT_PER_DEGREE   = 3'd5;
  localparam logic [2:0] REG_RANGE_START_POINT = 3'd6;
  localparam logic [2:0] REG_LAST_ENTRY        = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK0,
    ST_CHKL,
    ST_SRCH,
    ST_SEG,
    ST_DIV,
    ST_VOLT,
    ST_VSUM,
    ST_FMUL,
    ST_FSUM,
    ST_EMIT
  } ttvf_state_t;

endpackage

/* rtl/core/thermistor_temp_to_vco_freq_top.sv */
// Thermistor temperature to VCO frequency: table search, interpolation and scaling.
// Holds the temperature table in a synchronous RAM; uses ttvf_pkg.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | mode, temperature, entry_index, entry_value
//   out     | output    | out_valid / out_stall | frequency, clamp_kind
//   config  | input     | APB write, pready = 1 | pwdata at paddr 4*i
//
// A table write is done from idle without leaving it. A conversion walks the table
// one entry per cycle through the RAM read port, then runs a restoring divider and
// four multiply/add stages. Synchronous reset clears control and the configuration
// registers, with last_entry reset to 63; the table is undefined until written.
// One conversion is in flight at a time; a stalled result holds in the output
// register while the next item is taken.
module thermistor_temp_to_vco_freq_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic signed [23:0]  temperature,
  input  logic [5:0]          entry_index,
  input  logic signed [23:0]  entry_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [23:0]         frequency,
  output logic [1:0]          clamp_kind,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ttvf_pkg::*;

  // configuration registers
  logic [23:0]        zero_volt_freq;
  logic [23:0]        max_freq;
  logic [31:0]        volt_to_freq_gain;
  logic [23:0]        volt_per_point;
  logic signed [31:0] volt_at_start;
  logic [23:0]        volt_per_degree;
  logic               range_start_point;
  logic [5:0]         last_entry;

  // table RAM
  logic signed [23:0] mem [TABLE_DEPTH];
  logic               wr_en;
  logic [TBL_AW-1:0]  wr_addr;
  logic               rd_en;
  logic [TBL_AW-1:0]  rd_addr;
  logic signed [23:0] rd_data;

  ttvf_state_t        state;
  ttvf_state_t        state_next;

  logic signed [23:0] temp;
  logic signed [23:0] t0;
  logic signed [23:0] t1;
  logic signed [23:0] prev;
  logic signed [23:0] cur;
  logic [TBL_AW-1:0]  idx;
  logic [TBL_AW-1:0]  last_eff;
  logic [23:0]        dvsr;
  logic [25:0]        rem;
  logic [16:0]        quo;
  logic [DCNT_W-1:0]  div_cnt;
  logic signed [24:0] dt;
  logic signed [VP_W-1:0] vprod;
  logic               use_slope;
  logic signed [31:0] volt;
  logic signed [64:0] fprod;
  logic [23:0]        res_freq;
  logic [1:0]         res_kind;

  logic               cfg_wr;
  logic               out_free;
  logic               below;
  logic               above;
  logic               go_on;
  logic signed [24:0] d1;
  logic signed [24:0] d2;
  logic               flat;
  logic [26:0]        trial;
  logic [24:0]        rem_keep;
  logic [TBL_AW-1:0]  idx_m1;
  logic [QW-1:0]      idxq;
  logic               slope_c;
  logic signed [MA_W-1:0] mul_a;
  logic signed [24:0]     mul_b;
  logic signed [VP_W-1:0] vshift;
  logic signed [VP_W-1:0] vsum;
  logic signed [31:0]     vsat;
  logic signed [64:0]     fsum;
  logic [23:0]            fsat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (int'(last_entry) > TABLE_DEPTH - 1) begin
      last_eff = TBL_AW'(TABLE_DEPTH - 1);
    end else begin
      last_eff = TBL_AW'(last_entry);
    end
  end

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_volt_freq    <= '0;
      max_freq          <= '0;
      volt_to_freq_gain <= '0;
      volt_per_point    <= '0;
      volt_at_start     <= '0;
      volt_per_degree   <= '0;
      range_start_point <= 1'b0;
      last_entry        <= 6'd63;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_ZERO_VOLT_FREQ:    zero_volt_freq    <= pwdata[23:0];
        REG_MAX_FREQ:          max_freq          <= pwdata[23:0];
        REG_VOLT_TO_FREQ_GAIN: volt_to_freq_gain <= pwdata;
        REG_VOLT_PER_POINT:    volt_per_point    <= pwdata[23:0];
        REG_VOLT_AT_START:     volt_at_start     <= signed'(pwdata);
        REG_VOLT_PER_DEGREE:   volt_per_degree   <= pwdata[23:0];
        REG_RANGE_START_POINT: range_start_point <= pwdata[0];
        REG_LAST_ENTRY:        last_entry        <= pwdata[5:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ZERO_VOLT_FREQ:    prdata = {8'h00, zero_volt_freq};
      REG_MAX_FREQ:          prdata = {8'h00, max_freq};
      REG_VOLT_TO_FREQ_GAIN: prdata = volt_to_freq_gain;
      REG_VOLT_PER_POINT:    prdata = {8'h00, volt_per_point};
      REG_VOLT_AT_START:     prdata = volt_at_start;
      REG_VOLT_PER_DEGREE:   prdata = {8'h00, volt_per_degree};
      REG_RANGE_START_POINT: prdata = {31'h0, range_start_point};
      REG_LAST_ENTRY:        prdata = {26'h0, last_entry};
    endcase
  end

  // ---------------- table RAM ----------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= entry_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // ---------------- datapath terms ----------------
  assign below = temp <= rd_data;
  assign above = temp >= rd_data;
  assign go_on = temp > rd_data;

  assign d1   = 25'(temp) - 25'(prev);
  assign d2   = 25'(cur) - 25'(prev);
  assign flat = (d2 <= 25'sd0) || (d1 < 25'sd0);

  // one quotient bit per cycle
  assign trial    = {1'b0, rem} - {3'b000, dvsr};
  assign rem_keep = trial[26] ? rem[24:0] : trial[24:0];

  assign idx_m1  = idx - TBL_AW'(1);
  assign idxq    = QW'({idx_m1, 16'h0000}) + QW'(quo);
  assign slope_c = range_start_point && (idxq < QW'(17'h10000));
  assign mul_a   = slope_c ? MA_W'(dt) : signed'(MA_W'(idxq));
  assign mul_b   = signed'({1'b0, (slope_c ? volt_per_degree : volt_per_point)});

  assign vshift = use_slope ? (vprod >>> 8) : (vprod >>> 16);
  assign vsum   = vshift + VP_W'(volt_at_start);

  always_comb begin
    if (vsum[VP_W-1:31] == '0 || vsum[VP_W-1:31] == '1) begin
      vsat = vsum[31:0];
    end else if (vsum[VP_W-1]) begin
      vsat = 32'sh8000_0000;
    end else begin
      vsat = 32'sh7FFF_FFFF;
    end
  end

  assign fsum = (fprod >>> 24) + signed'({41'h0, zero_volt_freq});

  always_comb begin
    if (fsum[64]) begin
      fsat = 24'h000000;
    end else if (fsum[63:24] != '0) begin
      fsat = 24'hFF_FFFF;
    end else begin
      fsat = fsum[23:0];
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && !mode) state_next = ST_CHK0;
      ST_CHK0: state_next = below ? ST_EMIT : ST_CHKL;
      ST_CHKL: state_next = above ? ST_EMIT : ST_SRCH;
      ST_SRCH: begin
        if (!go_on) begin
          state_next = ST_SEG;
        end else if (idx == last_eff) begin
          state_next = ST_EMIT;
        end
      end
      ST_SEG:  state_next = flat ? ST_EMIT : ST_DIV;
      ST_DIV:  if (div_cnt == DCNT_W'(DIV_STEPS - 1)) state_next = ST_VOLT;
      ST_VOLT: state_next = ST_VSUM;
      ST_VSUM: state_next = ST_FMUL;
      ST_FMUL: state_next = ST_FSUM;
      ST_FSUM: state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = TBL_AW'(entry_index);
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid && !mode;
        wr_en    = in_valid && mode && (int'(entry_index) < TABLE_DEPTH);
      end
      ST_CHK0: begin
        rd_en   = !below;
        rd_addr = last_eff;
      end
      ST_CHKL: begin
        rd_en   = !above;
        rd_addr = TBL_AW'(1);
      end
      ST_SRCH: begin
        rd_en   = go_on && (idx != last_eff);
        rd_addr = idx + TBL_AW'(1);
      end
      default: begin
      end
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        temp <= temperature;
      end
      ST_CHK0: begin
        t0       <= rd_data;
        prev     <= rd_data;
        res_freq <= zero_volt_freq;
        res_kind <= KIND_BELOW;
      end
      ST_CHKL: begin
        idx      <= TBL_AW'(1);
        res_freq <= max_freq;
        res_kind <= KIND_ABOVE;
      end
      ST_SRCH: begin
        if (idx == TBL_AW'(1)) begin
          t1 <= rd_data;
        end
        if (go_on) begin
          prev <= rd_data;
          idx  <= idx + TBL_AW'(1);
        end else begin
          cur <= rd_data;
        end
      end
      ST_SEG: begin
        dvsr     <= d2[23:0];
        rem      <= 26'(d1[23:0]);
        quo      <= '0;
        div_cnt  <= '0;
        dt       <= range_start_point ? (25'(temp) - 25'(t1)) : (25'(temp) - 25'(t0));
        res_freq <= max_freq;
        res_kind <= KIND_FLAT;
      end
      ST_DIV: begin
        quo     <= {quo[15:0], !trial[26]};
        rem     <= {rem_keep, 1'b0};
        div_cnt <= div_cnt + DCNT_W'(1);
      end
      ST_VOLT: begin
        vprod     <= mul_a * mul_b;
        use_slope <= slope_c;
      end
      ST_VSUM: begin
        volt <= vsat;
      end
      ST_FMUL: begin
        fprod <= volt * signed'({1'b0, volt_to_freq_gain});
      end
      ST_FSUM: begin
        res_freq <= fsat;
        res_kind <= KIND_INTERP;
      end
      default: begin
      end
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      frequency  <= res_freq;
      clamp_kind <= res_kind;
    end
  end

endmodule

/* rtl/core/ttvf_checker.sv */
// Port-level checks for thermistor_temp_to_vco_freq_top, attached by bind.
// Uses ttvf_pkg for the clamp codes.
module ttvf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                mode,
  input logic                out_valid,
  input logic                out_stall,
  input logic [23:0]         frequency,
  input logic [1:0]          clamp_kind
);
  import ttvf_pkg::*;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frequency) && $stable(clamp_kind))
    else $error("output beat changed while stalled");

  // a table write does not stall further input
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode |=> !in_stall)
    else $error("table write did not return to idle");

  // a conversion holds off further input
  a_conv_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !mode |=> in_stall)
    else $error("input taken during conversion");

  // a new result only comes out of a conversion in flight
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without conversion");

  // a stalled below-table beat keeps its clamp kind
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamp_kind == KIND_BELOW |=> !out_valid || $stable(clamp_kind)
      || !$past(out_stall))
    else $error("below-table beat dropped");

endmodule

bind thermistor_temp_to_vco_freq_top ttvf_checker u_ttvf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .mode       (mode),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frequency  (frequency),
  .clamp_kind (clamp_kind)
);

/* dv/vco_freq_checker.sv */
// Scoreboard for the thermistor temperature to VCO frequency block: snoops the APB
// writes, the input beats and the result beats, predicts each conversion and compares.
// Depends on ttvf_pkg for table depth, register offsets and clamp codes.
module vco_freq_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               mode,
  input  logic signed [23:0] temperature,
  input  logic [5:0]         entry_index,
  input  logic signed [23:0] entry_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [23:0]        frequency,
  input  logic [1:0]         clamp_kind,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);
  import ttvf_pkg::*;

  typedef struct packed {
    logic signed [23:0] temp;
    logic [23:0]        freq;
    logic [1:0]         kind;
  } vco_result_t;

  // register shadow
  logic [23:0]        zero_hz;
  logic [23:0]        max_hz;
  logic [31:0]        hz_per_volt;
  logic [23:0]        volt_step;
  logic signed [31:0] volt_base;
  logic [23:0]        volt_slope;
  logic               start_pt;
  logic [5:0]         last_idx;

  logic signed [23:0] temp_tbl [TABLE_DEPTH];
  vco_result_t        freq_expect_q [$];
  int                 n_bad = 0;

  function automatic vco_result_t interp_vco_freq(input logic signed [23:0] temp_in);
    vco_result_t res;
    longint      t, d1, d2, frac, idxq, volt, f;
    int          i;
    res.temp = temp_in;
    res.freq = max_hz;
    res.kind = KIND_ABOVE;
    t = temp_in;
    if (t <= temp_tbl[0]) begin
      res.freq = zero_hz;
      res.kind = KIND_BELOW;
      return res;
    end
    if (t >= temp_tbl[last_idx]) return res;
    // first entry at or above the temperature; stop at the last valid entry
    i = 0;
    while (t > temp_tbl[i] && i != last_idx) i++;
    if (t > temp_tbl[i] || i == 0) return res;
    d1 = t - longint'(temp_tbl[i-1]);
    d2 = longint'(temp_tbl[i]) - longint'(temp_tbl[i-1]);
    if (d2 <= 0 || d1 < 0) begin
      res.kind = KIND_FLAT;
      return res;
    end
    frac = (d1 <<< 16) / d2;
    idxq = (longint'(i - 1) <<< 16) + frac;
    if (idxq < (longint'(start_pt) <<< 16))
      volt = (((t - longint'(temp_tbl[start_pt])) * longint'(volt_slope)) >>> 8)
             + longint'(volt_base);
    else
      volt = ((idxq * longint'(volt_step)) >>> 16) + longint'(volt_base);
    if (volt > 64'sd2147483647) volt = 64'sd2147483647;
    if (volt < -64'sd2147483648) volt = -64'sd2147483648;
    f = ((volt * longint'(hz_per_volt)) >>> 24) + longint'(zero_hz);
    if (f < 0) f = 0;
    if (f > 64'sd16777215) f = 64'sd16777215;
    res.freq = f[23:0];
    res.kind = KIND_INTERP;
    return res;
  endfunction

  function automatic void note_bad(input string msg);
    n_bad++;
    if (n_bad <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : snoop
    vco_result_t exp_r;
    if (rst) begin
      zero_hz     = '0;
      max_hz      = '0;
      hz_per_volt = '0;
      volt_step   = '0;
      volt_base   = '0;
      volt_slope  = '0;
      start_pt    = 1'b0;
      last_idx    = 6'd63;
      freq_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ZERO_VOLT_FREQ:    zero_hz     = pwdata[23:0];
          REG_MAX_FREQ:          max_hz      = pwdata[23:0];
          REG_VOLT_TO_FREQ_GAIN: hz_per_volt = pwdata;
          REG_VOLT_PER_POINT:    volt_step   = pwdata[23:0];
          REG_VOLT_AT_START:     volt_base   = pwdata;
          REG_VOLT_PER_DEGREE:   volt_slope  = pwdata[23:0];
          REG_RANGE_START_POINT: start_pt    = pwdata[0];
          REG_LAST_ENTRY:        last_idx    = pwdata[5:0];
          default: ;
        endcase
      end
      // retire the result beat before queuing this edge's input beat
      if (out_valid && !out_stall) begin
        if (freq_expect_q.size() == 0) begin
          note_bad($sformatf("unexpected result: frequency %0d kind %0d",
                             frequency, clamp_kind));
        end else begin
          exp_r = freq_expect_q.pop_front();
          if (frequency !== exp_r.freq || clamp_kind !== exp_r.kind)
            note_bad($sformatf("mismatch for temp %0d: frequency %0d kind %0d, got %0d kind %0d",
                               exp_r.temp, exp_r.freq, exp_r.kind, frequency, clamp_kind));
        end
      end
      if (in_valid && !in_stall) begin
        if (mode)
          temp_tbl[entry_index] = entry_value;
        else
          freq_expect_q.push_back(interp_vco_freq(temperature));
      end
    end
    pending    <= freq_expect_q.size();
    fail_count <= n_bad;
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for thermistor_temp_to_vco_freq_top: clock, reset, APB register phases,
// table loads, conversions with random idling on both channels, watchdog and verdict.
// Depends on ttvf_pkg and on vco_freq_checker for prediction and comparison.
module tb_top;
  import ttvf_pkg::*;

  localparam int TEMP_MIN        = -8388608;
  localparam int TEMP_MAX        = 8388607;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 146;
  localparam int SETTLE_CYCLES   = 100;
  localparam int QUIET_LIMIT     = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic signed [23:0] temperature = '0;
  logic [5:0]         entry_index = '0;
  logic signed [23:0] entry_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [23:0]        frequency;
  logic [1:0]         clamp_kind;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;

  int tbl_shadow [TABLE_DEPTH];
  int cur_last = 63;
  bit calm = 1'b0;
  int n_conv = 0;
  int n_write = 0;
  int hold_cnt = 0;
  int quiet = 0;

  thermistor_temp_to_vco_freq_top dut (.*);
  vco_freq_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic int clamp_temp(input longint v);
    if (v < TEMP_MIN) return TEMP_MIN;
    if (v > TEMP_MAX) return TEMP_MAX;
    return int'(v);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin : rx_hold
    int n;
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      n = gap_len();
      out_stall <= (n != 0);
      hold_cnt <= (n > 1) ? n - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding", quiet, pending);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic put_item(input logic m, input logic signed [23:0] t,
                          input logic [5:0] idx, input logic signed [23:0] v);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    temperature <= t;
    entry_index <= idx;
    entry_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic convert(input int t);
    put_item(1'b0, t[23:0], 6'($urandom), 24'($urandom));
    n_conv++;
  endtask

  task automatic table_write(input int idx, input int v);
    put_item(1'b1, 24'($urandom), idx[5:0], v[23:0]);
    tbl_shadow[idx] = v;
    n_write++;
  endtask

  // hold the sender until every queued conversion has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_reg(input int p, input logic [31:0] lo,
                                           input logic [31:0] hi, input logic [31:0] rnd);
    int r;
    r = $urandom_range(0, 5);
    if (p == 1 || (p > 2 && r == 0)) return lo;
    if (p == 2 || (p > 2 && r == 1)) return hi;
    return rnd;
  endfunction

  // phase 0 is a plausible setting, 1 all low ends, 2 all high ends, the rest mixed
  task automatic configure(input int p);
    logic [31:0] v [8];
    if (p == 0) begin
      v[REG_ZERO_VOLT_FREQ]    = 32'd2000000;
      v[REG_MAX_FREQ]          = 32'd9000000;
      v[REG_VOLT_TO_FREQ_GAIN] = 32'd25600000;
      v[REG_VOLT_PER_POINT]    = 32'd2048;
      v[REG_VOLT_AT_START]     = 32'd65536;
      v[REG_VOLT_PER_DEGREE]   = 32'd512;
      v[REG_RANGE_START_POINT] = 32'd1;
      v[REG_LAST_ENTRY]        = 32'd63;
    end else begin
      v[REG_ZERO_VOLT_FREQ]    = pick_reg(p, 0, 24'hFFFFFF,
                                          ($urandom & 24'hFFFFFF) >> $urandom_range(0, 12));
      v[REG_MAX_FREQ]          = pick_reg(p, 0, 24'hFFFFFF,
                                          ($urandom & 24'hFFFFFF) >> $urandom_range(0, 12));
      v[REG_VOLT_TO_FREQ_GAIN] = pick_reg(p, 0, 32'hFFFFFFFF,
                                          $urandom >> $urandom_range(0, 24));
      v[REG_VOLT_PER_POINT]    = pick_reg(p, 0, 24'hFFFFFF,
                                          ($urandom & 24'hFFFFFF) >> $urandom_range(0, 20));
      v[REG_VOLT_AT_START]     = pick_reg(p, 32'h80000000, 32'h7FFFFFFF,
                                          32'($signed($urandom) >>> $urandom_range(0, 24)));
      v[REG_VOLT_PER_DEGREE]   = pick_reg(p, 0, 24'hFFFFFF,
                                          ($urandom & 24'hFFFFFF) >> $urandom_range(0, 20));
      v[REG_RANGE_START_POINT] = pick_reg(p, 0, 1, $urandom_range(0, 1));
      v[REG_LAST_ENTRY]        = pick_reg(p, 1, 63, ($urandom_range(0, 2) == 0) ?
                                          $urandom_range(1, 4) : $urandom_range(1, 63));
    end
    for (int r = 0; r < 8; r++) reg_write(3'(r), v[r]);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_last = v[REG_LAST_ENTRY][5:0];
  endtask

  // ascending table with an occasional repeated entry
  task automatic load_table(input int n);
    int maxstep, v;
    case ($urandom_range(0, 2))
      0:       maxstep = 16;
      1:       maxstep = 2000;
      default: maxstep = 262000;
    endcase
    v = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN - (TABLE_DEPTH - 1) * maxstep));
    for (int e = 0; e < n; e++) begin
      table_write(e, v);
      v += ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(1, maxstep));
    end
  endtask

  function automatic int pick_temp();
    int lo, hi, r;
    lo = tbl_shadow[0];
    hi = tbl_shadow[cur_last];
    r = $urandom_range(0, 99);
    if (r < 70 && hi > lo) return lo + int'($urandom_range(0, hi - lo));
    if (r < 82) return tbl_shadow[$urandom_range(0, cur_last)];
    if (r < 91) return $signed(24'($urandom));
    return clamp_temp(longint'(r[0] ? hi : lo) + $signed(4'($urandom)));
  endfunction

  task automatic random_write();
    int idx, lo, hi, r;
    idx = ($urandom_range(0, 6) == 0) ? $urandom_range(0, TABLE_DEPTH - 1)
                                      : $urandom_range(0, cur_last);
    lo = (idx > 0) ? tbl_shadow[idx - 1] : TEMP_MIN;
    hi = (idx < TABLE_DEPTH - 1) ? tbl_shadow[idx + 1] : TEMP_MAX;
    r = $urandom_range(0, 99);
    if (r < 70 && hi >= lo)
      table_write(idx, lo + int'($urandom_range(0, hi - lo)));
    else if (r < 85)
      table_write(idx, lo);
    else
      table_write(idx, $signed(24'($urandom)));
  endtask

  task automatic directed_items();
    int keep_lo, keep_hi;
    keep_lo = tbl_shadow[0];
    keep_hi = tbl_shadow[TABLE_DEPTH - 1];
    // stretch the table to the full temperature range
    table_write(0, TEMP_MIN);
    table_write(TABLE_DEPTH - 1, TEMP_MAX);
    convert(TEMP_MIN);
    convert(TEMP_MAX);
    convert(TEMP_MIN + 1);
    convert(TEMP_MAX - 1);
    table_write(0, keep_lo);
    table_write(TABLE_DEPTH - 1, keep_hi);
    convert(keep_lo);
    convert(keep_hi);
    // exact entry hit: fraction reaches a full step
    convert(tbl_shadow[1]);
    convert(clamp_temp(longint'(tbl_shadow[1]) - 1));
    // first segment lies below the range start point: slope path
    convert(clamp_temp((longint'(tbl_shadow[0]) + tbl_shadow[1]) / 2));
    convert(clamp_temp((longint'(tbl_shadow[30]) + tbl_shadow[31]) / 2));
    convert(clamp_temp(longint'(tbl_shadow[62]) + 1));
    convert(0);
    convert(-1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < N_PHASES; p++) begin
      calm = (p == 3 || p == 6);
      settle();
      configure(p);
      load_table((p == 0) ? TABLE_DEPTH : cur_last + 1);
      if (p == 0) directed_items();
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) == 0) drain_results();
        if ($urandom_range(0, 99) < 86)
          convert(pick_temp());
        else
          random_write();
      end
    end
    settle();
    $display("covered %0d conversions and %0d table writes over %0d register settings",
             n_conv, n_write, N_PHASES);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ttvf_pkg.sv
rtl/core/thermistor_temp_to_vco_freq_top.sv
rtl/core/ttvf_checker.sv
dv/vco_freq_checker.sv
dv/tb_top.sv
